// ----- design/bffa_pkg.sv -----
// Package for the bitmap first-fit allocator: sizes, request and status codes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package bffa_pkg;

  localparam int ITEMS    = 4096;
  localparam int MAX_RUN  = 16;
  localparam int WORD_W   = 64;
  localparam int WORDS    = ITEMS / WORD_W;
  localparam int ADDR_W   = $clog2(WORDS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int ITEM_W   = 13;
  localparam int KIND_W   = 3;
  localparam int RL_W     = 5;
  localparam int STAT_W   = 2;
  localparam int RUN_IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK_USED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MARK_FREE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_FREE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ALLOC_RUN = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    EM_BAD,
    EM_ITEM,
    EM_FIND,
    EM_ZERO,
    EM_RUN,
    EM_SHORT
  } emit_sel_t;

  typedef struct packed {
    logic      latch;
    logic      item_rd;
    logic      item_mod;
    logic      scan_start;
    logic      scan_step;
    logic      emit;
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              item_bad;
    logic              run_zero;
    logic              lim_zero;
    logic              hit;
    logic              full_after;
    logic              last_word;
    logic              run_short;
    logic              run_empty;
    logic              k_last;
  } dp_stat_t;

endpackage

// ----- design/bitmap_first_fit_allocator_core.sv -----
// Top level of the bitmap first-fit allocator: a controller and a datapath.
// Depends on bffa_pkg, bffa_ctrl and bffa_datapath.
//
// A request is taken when start is high and busy is low. Each result appears
// for exactly one cycle with out_valid high, and the receiver cannot stall it;
// out_last marks the final result of a request, and out_free_left is the free
// count after the whole request. The bitmap is held as 64-bit words in one
// memory with a registered read port. The scan reads and tests one word per
// cycle while it finds no free item; for a run it marks each free item found
// in a word before it moves on. A query or mark reads and updates one word.
// A free search scans up to total_count/64 words rounded up, 64 at most. A
// run allocation marks its items first, then gives one result per item found
// and an ST_NONE result if the run comes up short. busy drops in the cycle of
// the final result, and a new request may start then. Reset leaves the whole
// bitmap free at once, with no clearing pass. total_count may be written
// whenever busy is low.
module bitmap_first_fit_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bffa_pkg::KIND_W-1:0]  in_kind,
  input  logic [bffa_pkg::ITEM_W-1:0]  in_item_number,
  input  logic [bffa_pkg::RL_W-1:0]    in_run_length,
  output logic                         out_valid,
  output logic [bffa_pkg::ITEM_W-1:0]  out_result_item,
  output logic                         out_bit_value,
  output logic [bffa_pkg::ITEM_W-1:0]  out_free_left,
  output logic [bffa_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bffa_pkg::ITEM_W-1:0]  cfg_total_count
);
  import bffa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_wr;

  assign cfg_ready = ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  bffa_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_item_number  (in_item_number),
    .in_run_length   (in_run_length),
    .cfg_wr          (cfg_wr),
    .cfg_total_count (cfg_total_count),
    .out_valid       (out_valid),
    .out_result_item (out_result_item),
    .out_bit_value   (out_bit_value),
    .out_free_left   (out_free_left),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

// ----- design/bffa_bitmap_mem.sv -----
// Allocation bitmap storage: one write port and one registered read port.
// A per-row valid bit cleared at reset makes unwritten rows read as all free.
// Depends on bffa_pkg.
module bffa_bitmap_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [bffa_pkg::ADDR_W-1:0]  rd_addr,
  output logic [bffa_pkg::WORD_W-1:0]  rd_data,
  input  logic                         wr_en,
  input  logic [bffa_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [bffa_pkg::WORD_W-1:0]  wr_data
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  row_valid_r;
  logic [WORD_W-1:0] q_r;
  logic              qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      qv_r        <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        qv_r <= row_valid_r[rd_addr];
      end
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

// ----- design/bffa_datapath.sv -----
// Datapath of the allocator: request registers, free counter, scan word logic,
// found-item buffer and result registers. Depends on bffa_pkg and bffa_bitmap_mem.
module bffa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bffa_pkg::dp_cmd_t            cmd,
  output bffa_pkg::dp_stat_t           stat,
  input  logic [bffa_pkg::KIND_W-1:0]  in_kind,
  input  logic [bffa_pkg::ITEM_W-1:0]  in_item_number,
  input  logic [bffa_pkg::RL_W-1:0]    in_run_length,
  input  logic                         cfg_wr,
  input  logic [bffa_pkg::ITEM_W-1:0]  cfg_total_count,
  output logic                         out_valid,
  output logic [bffa_pkg::ITEM_W-1:0]  out_result_item,
  output logic                         out_bit_value,
  output logic [bffa_pkg::ITEM_W-1:0]  out_free_left,
  output logic [bffa_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last
);
  import bffa_pkg::*;

  logic [ITEM_W-1:0]   total_r;
  logic [ITEM_W-1:0]   count_r;
  logic [KIND_W-1:0]   kind_r;
  logic [ITEM_W-1:0]   item_r;
  logic [RL_W-1:0]     len_r;
  logic                item_bad_r;
  logic [ADDR_W-1:0]   last_w_r;
  logic [BIT_W-1:0]    lim_rem_r;
  logic                lim_zero_r;
  logic [ADDR_W-1:0]   w_r;
  logic                fresh_r;
  logic [WORD_W-1:0]   work_r;
  logic [RL_W-1:0]     n_r;
  logic [RUN_IDX_W-1:0] k_r;
  logic [ITEM_W-1:0]   found_r [MAX_RUN];
  logic [ITEM_W-1:0]   find_item_r;
  logic                bit_r;

  logic                out_valid_r;
  logic [ITEM_W-1:0]   out_item_r;
  logic                out_bit_r;
  logic [ITEM_W-1:0]   out_free_r;
  logic [STAT_W-1:0]   out_status_r;
  logic                out_last_r;

  logic [ITEM_W-1:0]   lim;
  logic [ITEM_W-1:0]   lim_m1;
  logic [RL_W-1:0]     len_sat;
  logic [ITEM_W-1:0]   idx;
  logic [ADDR_W-1:0]   idx_word;
  logic [BIT_W-1:0]    idx_bit;
  logic                item_bad;
  logic [WORD_W-1:0]   mem_q;
  logic [WORD_W-1:0]   cur;
  logic [WORD_W-1:0]   lim_mask;
  logic [WORD_W-1:0]   avail;
  logic [BIT_W-1:0]    pick;
  logic [WORD_W-1:0]   pick_bit;
  logic                hit;
  logic                last_word;
  logic [ITEM_W-1:0]   pick_item;
  logic                old_bit;
  logic                new_bit;
  logic [WORD_W-1:0]   item_word;
  logic                item_flip;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [WORD_W-1:0]   mem_wr_data;
  logic                inc;
  logic                dec;
  logic [ITEM_W-1:0]   count_nxt;
  logic                k_last;
  logic                run_short;

  bffa_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_q),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign lim     = (total_r > ITEM_W'(ITEMS)) ? ITEM_W'(ITEMS) : total_r;
  assign lim_m1  = lim - 1'b1;
  assign len_sat = (in_run_length > RL_W'(MAX_RUN)) ? RL_W'(MAX_RUN) : in_run_length;
  assign item_bad = (in_item_number == '0) || (in_item_number > ITEM_W'(ITEMS));

  assign idx      = item_r - 1'b1;
  assign idx_word = idx[ADDR_W+BIT_W-1:BIT_W];
  assign idx_bit  = idx[BIT_W-1:0];

  assign cur       = fresh_r ? mem_q : work_r;
  assign last_word = (w_r == last_w_r);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      lim_mask[j] = !last_word || (BIT_W'(j) <= lim_rem_r);
    end
  end

  assign avail = ~cur & lim_mask;
  assign hit   = |avail;

  always_comb begin
    pick = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        pick = BIT_W'(j);
      end
    end
  end

  assign pick_bit  = WORD_W'(1) << pick;
  assign pick_item = ITEM_W'({w_r, pick}) + 1'b1;

  always_comb begin
    old_bit = mem_q[idx_bit];
    case (kind_r)
      KIND_MARK_USED: new_bit = 1'b1;
      KIND_MARK_FREE: new_bit = 1'b0;
      default:        new_bit = old_bit;
    endcase
    item_word          = mem_q;
    item_word[idx_bit] = new_bit;
  end

  assign item_flip = cmd.item_mod && (old_bit != new_bit);

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = w_r + 1'b1;
    if (cmd.item_rd) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = idx_word;
    end else if (cmd.scan_start) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = '0;
    end else if (cmd.scan_step && !hit && !last_word) begin
      mem_rd_en   = 1'b1;
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = w_r;
    mem_wr_data = cur | pick_bit;
    if (item_flip) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = idx_word;
      mem_wr_data = item_word;
    end else if (cmd.scan_step && hit && (kind_r == KIND_ALLOC_RUN)) begin
      mem_wr_en   = 1'b1;
    end
  end

  assign dec = (item_flip && new_bit) ||
               (cmd.scan_step && hit && (kind_r == KIND_ALLOC_RUN));
  assign inc = item_flip && !new_bit;

  always_comb begin
    count_nxt = count_r;
    if (dec && (count_r != '0)) begin
      count_nxt = count_r - 1'b1;
    end else if (inc && (count_r < ITEM_W'(ITEMS))) begin
      count_nxt = count_r + 1'b1;
    end
  end

  assign k_last    = ((RL_W'(k_r) + 1'b1) == n_r);
  assign run_short = (n_r != len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= ITEM_W'(ITEMS);
      count_r     <= ITEM_W'(ITEMS);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        total_r <= cfg_total_count;
      end
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r      <= in_kind;
      item_r      <= in_item_number;
      len_r       <= len_sat;
      item_bad_r  <= item_bad;
      last_w_r    <= lim_m1[ADDR_W+BIT_W-1:BIT_W];
      lim_rem_r   <= lim_m1[BIT_W-1:0];
      lim_zero_r  <= (lim == '0);
      w_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      fresh_r     <= 1'b0;
      find_item_r <= '0;
    end
    if (cmd.item_mod) begin
      bit_r <= new_bit;
    end
    if (cmd.scan_start) begin
      fresh_r <= 1'b1;
    end
    if (cmd.scan_step) begin
      if (hit) begin
        if (kind_r == KIND_ALLOC_RUN) begin
          work_r                     <= cur | pick_bit;
          fresh_r                    <= 1'b0;
          found_r[n_r[RUN_IDX_W-1:0]] <= pick_item;
          n_r                        <= n_r + 1'b1;
        end else begin
          find_item_r <= pick_item;
        end
      end else if (!last_word) begin
        w_r     <= w_r + 1'b1;
        fresh_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_free_r <= count_r;
      out_bit_r  <= 1'b0;
      out_last_r <= 1'b1;
      case (cmd.emit_sel)
        EM_ITEM: begin
          out_item_r   <= item_r;
          out_bit_r    <= bit_r;
          out_status_r <= ST_OK;
        end
        EM_FIND: begin
          out_item_r   <= find_item_r;
          out_status_r <= (find_item_r == '0) ? ST_NONE : ST_OK;
        end
        EM_ZERO: begin
          out_item_r   <= '0;
          out_status_r <= ST_OK;
        end
        EM_RUN: begin
          out_item_r   <= found_r[k_r];
          out_status_r <= ST_OK;
          out_last_r   <= k_last && !run_short;
          k_r          <= k_r + 1'b1;
        end
        EM_SHORT: begin
          out_item_r   <= '0;
          out_status_r <= ST_NONE;
        end
        default: begin
          out_item_r   <= '0;
          out_status_r <= ST_RANGE;
        end
      endcase
    end
  end

  always_comb begin
    stat.kind       = kind_r;
    stat.item_bad   = item_bad_r;
    stat.run_zero   = (len_r == '0);
    stat.lim_zero   = lim_zero_r;
    stat.hit        = hit;
    stat.full_after = ((n_r + 1'b1) == len_r);
    stat.last_word  = last_word;
    stat.run_short  = run_short;
    stat.run_empty  = (n_r == '0);
    stat.k_last     = k_last;
  end

  assign out_valid       = out_valid_r;
  assign out_result_item = out_item_r;
  assign out_bit_value   = out_bit_r;
  assign out_free_left   = out_free_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

// ----- design/bffa_ctrl.sv -----
// Controller of the allocator: sequences request decode, bitmap access, the
// word scan and result emission. Depends on bffa_pkg.
module bffa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output bffa_pkg::dp_cmd_t   cmd,
  input  bffa_pkg::dp_stat_t  stat
);
  import bffa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ITEM_RD,
    S_ITEM_MOD,
    S_SCAN_RD,
    S_SCAN_PICK,
    S_EMIT_RUN,
    S_EMIT
  } state_t;

  state_t    state_r;
  state_t    state_nxt;
  emit_sel_t em_sel_r;
  emit_sel_t em_sel_nxt;
  logic      busy_r;

  always_comb begin
    state_nxt  = state_r;
    em_sel_nxt = em_sel_r;
    cmd        = '0;
    cmd.emit_sel = em_sel_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_QUERY, KIND_MARK_USED, KIND_MARK_FREE: begin
            if (stat.item_bad) begin
              em_sel_nxt = EM_BAD;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_ITEM_RD;
            end
          end
          KIND_FIND_FREE: begin
            if (stat.lim_zero) begin
              em_sel_nxt = EM_FIND;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          KIND_ALLOC_RUN: begin
            if (stat.run_zero) begin
              em_sel_nxt = EM_ZERO;
              state_nxt  = S_EMIT;
            end else if (stat.lim_zero) begin
              em_sel_nxt = EM_SHORT;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          default: begin
            em_sel_nxt = EM_BAD;
            state_nxt  = S_EMIT;
          end
        endcase
      end
      S_ITEM_RD: begin
        cmd.item_rd = 1'b1;
        state_nxt   = S_ITEM_MOD;
      end
      S_ITEM_MOD: begin
        cmd.item_mod = 1'b1;
        em_sel_nxt   = EM_ITEM;
        state_nxt    = S_EMIT;
      end
      S_SCAN_RD: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN_PICK;
      end
      S_SCAN_PICK: begin
        cmd.scan_step = 1'b1;
        if (stat.kind == KIND_FIND_FREE) begin
          if (stat.hit || stat.last_word) begin
            em_sel_nxt = EM_FIND;
            state_nxt  = S_EMIT;
          end
        end else if (stat.hit) begin
          if (stat.full_after) begin
            state_nxt = S_EMIT_RUN;
          end
        end else if (stat.last_word) begin
          if (stat.run_empty) begin
            em_sel_nxt = EM_SHORT;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_EMIT_RUN;
          end
        end
      end
      S_EMIT_RUN: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EM_RUN;
        if (stat.k_last) begin
          if (stat.run_short) begin
            em_sel_nxt = EM_SHORT;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      em_sel_r <= EM_BAD;
      busy_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      em_sel_r <= em_sel_nxt;
      busy_r   <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- verif/bffa_alloc_checker.sv -----
// Checker for the bitmap first-fit allocator: keeps its own copy of the bitmap,
// free count and search limit, predicts each request's results and compares them.
// Depends on bffa_pkg.
module bffa_alloc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [bffa_pkg::KIND_W-1:0] in_kind,
  input  logic [bffa_pkg::ITEM_W-1:0] in_item_number,
  input  logic [bffa_pkg::RL_W-1:0]   in_run_length,
  input  logic                        out_valid,
  input  logic [bffa_pkg::ITEM_W-1:0] out_result_item,
  input  logic                        out_bit_value,
  input  logic [bffa_pkg::ITEM_W-1:0] out_free_left,
  input  logic [bffa_pkg::STAT_W-1:0] out_status,
  input  logic                        out_last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bffa_pkg::ITEM_W-1:0] cfg_total_count,
  output int                          mismatches,
  output int                          replies_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic              bit_v;
    logic [ITEM_W-1:0] free;
    logic [STAT_W-1:0] status;
    logic              last;
  } reply_t;

  reply_t            replies_q[$];
  bit                used_map[ITEMS];
  logic [ITEM_W-1:0] free_items;
  logic [ITEM_W-1:0] scan_total;

  initial begin
    mismatches  = 0;
    replies_due = 0;
  end

  function automatic reply_t grant_reply(input int item, input bit bit_v,
                                         input logic [STAT_W-1:0] st, input bit last);
    reply_t r;
    r.item   = item[ITEM_W-1:0];
    r.bit_v  = bit_v;
    r.free   = free_items;
    r.status = st;
    r.last   = last;
    return r;
  endfunction

  task automatic set_used(input int idx, input bit v);
    if (used_map[idx] != v) begin
      used_map[idx] = v;
      if (v) begin
        if (free_items > 0) free_items = free_items - 1'b1;
      end else begin
        if (int'(free_items) < ITEMS) free_items = free_items + 1'b1;
      end
    end
  endtask

  task automatic predict_request(input logic [KIND_W-1:0] kind,
                                 input logic [ITEM_W-1:0] item_no,
                                 input logic [RL_W-1:0] len_in);
    int lim;
    int want;
    int n;
    int item_i;
    int found[MAX_RUN];
    lim    = (int'(scan_total) < ITEMS) ? int'(scan_total) : ITEMS;
    item_i = int'(item_no);
    want   = int'(len_in);
    n      = 0;
    case (kind)
      KIND_QUERY, KIND_MARK_USED, KIND_MARK_FREE: begin
        if (item_i == 0 || item_i > ITEMS) begin
          replies_q.push_back(grant_reply(0, 1'b0, ST_RANGE, 1'b1));
        end else begin
          if (kind == KIND_MARK_USED) set_used(item_i - 1, 1'b1);
          else if (kind == KIND_MARK_FREE) set_used(item_i - 1, 1'b0);
          replies_q.push_back(grant_reply(item_i, used_map[item_i-1], ST_OK, 1'b1));
        end
      end
      KIND_FIND_FREE: begin
        for (int i = 0; i < lim; i++) begin
          if (!used_map[i]) begin
            n = i + 1;
            break;
          end
        end
        if (n != 0) replies_q.push_back(grant_reply(n, 1'b0, ST_OK, 1'b1));
        else replies_q.push_back(grant_reply(0, 1'b0, ST_NONE, 1'b1));
      end
      KIND_ALLOC_RUN: begin
        if (want > MAX_RUN) want = MAX_RUN;
        if (want == 0) begin
          replies_q.push_back(grant_reply(0, 1'b0, ST_OK, 1'b1));
        end else begin
          for (int i = 0; i < lim && n < want; i++) begin
            if (!used_map[i]) begin
              set_used(i, 1'b1);
              found[n] = i + 1;
              n++;
            end
          end
          for (int k = 0; k < n; k++) begin
            replies_q.push_back(grant_reply(found[k], 1'b0, ST_OK,
                                            (n == want) && (k == n - 1)));
          end
          if (n < want) replies_q.push_back(grant_reply(0, 1'b0, ST_NONE, 1'b1));
        end
      end
      default: begin
        replies_q.push_back(grant_reply(0, 1'b0, ST_RANGE, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_reply();
    reply_t exp;
    if (replies_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: item %0d status %0d",
                                out_result_item, out_status));
    end else begin
      exp = replies_q.pop_front();
      if (out_result_item !== exp.item)
        report_mismatch($sformatf("result_item %0d, expected %0d", out_result_item, exp.item));
      if (out_bit_value !== exp.bit_v)
        report_mismatch($sformatf("bit_value %0d, expected %0d (item %0d)",
                                  out_bit_value, exp.bit_v, exp.item));
      if (out_free_left !== exp.free)
        report_mismatch($sformatf("free_left %0d, expected %0d (item %0d)",
                                  out_free_left, exp.free, exp.item));
      if (out_status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d (item %0d)",
                                  out_status, exp.status, exp.item));
      if (out_last !== exp.last)
        report_mismatch($sformatf("last %0d, expected %0d (item %0d)",
                                  out_last, exp.last, exp.item));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (used_map[i]) used_map[i] = 1'b0;
      free_items = ITEMS[ITEM_W-1:0];
      scan_total = 13'd4096;
      replies_q.delete();
    end else begin
      if (out_valid) check_reply();
      if (cfg_valid && cfg_ready) scan_total = cfg_total_count;
      if (start && !busy) predict_request(in_kind, in_item_number, in_run_length);
    end
    replies_due <= replies_q.size();
  end

endmodule

// ----- verif/bitmap_first_fit_allocator_core_tb.sv -----
// Testbench top for bitmap_first_fit_allocator_core: drives directed and random
// requests and search-limit settings, and gives the verdict from the checker.
// Depends on bffa_pkg, bffa_alloc_checker and the allocator RTL.
module bitmap_first_fit_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 60;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = KIND_ALLOC_RUN + 1'b1;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = '1;
  localparam logic [ITEM_W-1:0] ITEM_NUMBER_MAX   = '1;
  localparam logic [RL_W-1:0]   RUN_LENGTH_MAX    = '1;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [ITEM_W-1:0] in_item_number;
  logic [RL_W-1:0]   in_run_length;
  logic              out_valid;
  logic [ITEM_W-1:0] out_result_item;
  logic              out_bit_value;
  logic [ITEM_W-1:0] out_free_left;
  logic [STAT_W-1:0] out_status;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ITEM_W-1:0] cfg_total_count;
  int                mismatches;
  int                replies_due;
  int                cycle_count = 0;
  bit                idle_on;

  int phase_totals[8] = '{4096, 1, 64, 0, 8191, 65, 200, 4096};

  initial clk = 1'b0;
  always #10 clk = ~clk;

  bitmap_first_fit_allocator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_item_number  (in_item_number),
    .in_run_length   (in_run_length),
    .out_valid       (out_valid),
    .out_result_item (out_result_item),
    .out_bit_value   (out_bit_value),
    .out_free_left   (out_free_left),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_total_count (cfg_total_count)
  );

  bffa_alloc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_item_number  (in_item_number),
    .in_run_length   (in_run_length),
    .out_valid       (out_valid),
    .out_result_item (out_result_item),
    .out_bit_value   (out_bit_value),
    .out_free_left   (out_free_left),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_total_count (cfg_total_count),
    .mismatches      (mismatches),
    .replies_due     (replies_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic issue_request(input logic [KIND_W-1:0] kind, input int item_no,
                               input int run_len);
    while (idle_on && $urandom_range(0, 99) < 6) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_kind        <= kind;
    in_item_number <= item_no[ITEM_W-1:0];
    in_run_length  <= run_len[RL_W-1:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (replies_due != 0) @(negedge clk);
  endtask

  task automatic write_total_count(input int value);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_total_count <= value[ITEM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(input int total);
    int pick;
    int hi;
    int item_no;
    int run_len;
    logic [KIND_W-1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 30) kind = KIND_ALLOC_RUN;
    else if (pick < 55) kind = KIND_MARK_FREE;
    else if (pick < 68) kind = KIND_MARK_USED;
    else if (pick < 82) kind = KIND_FIND_FREE;
    else if (pick < 94) kind = KIND_QUERY;
    else kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    hi = (total == 0) ? 8 : ((total > ITEMS) ? ITEMS : total + 1);
    if ($urandom_range(0, 99) < 70) item_no = $urandom_range(1, hi);
    else item_no = $urandom_range(0, ITEM_NUMBER_MAX);
    if ($urandom_range(0, 99) < 80) run_len = $urandom_range(1, MAX_RUN);
    else run_len = $urandom_range(0, RUN_LENGTH_MAX);
    issue_request(kind, item_no, run_len);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_QUERY;
    in_item_number  = '0;
    in_run_length   = '0;
    cfg_valid       = 1'b0;
    cfg_total_count = '0;
    idle_on         = 1'b1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    write_total_count(ITEMS);
    issue_request(KIND_QUERY, 1, 0);
    issue_request(KIND_QUERY, ITEMS, 0);
    issue_request(KIND_QUERY, 0, 0);
    issue_request(KIND_QUERY, ITEMS + 1, 0);
    issue_request(KIND_QUERY, ITEM_NUMBER_MAX, 0);
    issue_request(KIND_MARK_USED, 1, 0);
    issue_request(KIND_MARK_USED, 1, 0);
    issue_request(KIND_MARK_FREE, 1, 0);
    issue_request(KIND_MARK_FREE, 1, 0);
    issue_request(KIND_MARK_USED, ITEMS, 0);
    issue_request(KIND_MARK_USED, 0, 0);
    issue_request(KIND_MARK_FREE, ITEMS + 1, 0);
    issue_request(KIND_FIND_FREE, 0, 0);
    issue_request(KIND_ALLOC_RUN, 0, 0);
    issue_request(KIND_ALLOC_RUN, 0, MAX_RUN);
    issue_request(KIND_ALLOC_RUN, ITEM_NUMBER_MAX, RUN_LENGTH_MAX);
    issue_request(KIND_ALLOC_RUN, 0, MAX_RUN + 1);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) begin
      issue_request(k[KIND_W-1:0], 5, 3);
    end
    issue_request(KIND_FIND_FREE, 0, 0);
    drain_replies();
    write_total_count(60);
    issue_request(KIND_ALLOC_RUN, 0, MAX_RUN);
    issue_request(KIND_ALLOC_RUN, 0, MAX_RUN);
    issue_request(KIND_FIND_FREE, 0, 0);
    drain_replies();
    write_total_count(0);
    issue_request(KIND_FIND_FREE, 0, 0);
    issue_request(KIND_ALLOC_RUN, 0, 3);
    drain_replies();

    for (int p = 0; p < 8; p++) begin
      drain_replies();
      write_total_count(phase_totals[p]);
      idle_on = (p != 2 && p != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(phase_totals[p]);
    end
    idle_on = 1'b1;

    drain_replies();
    repeat (150) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- bitmap_first_fit_allocator_core.f -----
design/bffa_pkg.sv
design/bffa_bitmap_mem.sv
design/bffa_datapath.sv
design/bffa_ctrl.sv
design/bitmap_first_fit_allocator_core.sv
verif/bffa_alloc_checker.sv
verif/bitmap_first_fit_allocator_core_tb.sv
